FILE: rtl/dda_pkg.sv
// Package with the shared types, codes and constants of the DDA line rasterizer.
package dda_pkg;

    localparam int COORD_BITS        = 10;
    localparam int DEFAULT_FRAC_BITS = 16;

    typedef enum logic
    {
        CMD_START = 1'b0,
        CMD_TICK  = 1'b1
    } command_t;

    typedef struct packed
    {
        logic                  command;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
    } cmd_item_t;

    typedef struct packed
    {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic                  pixel_valid;
        logic                  last;
    } pix_item_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_START_X,
        ST_WAIT_X,
        ST_WAIT_Y
    } state_t;

    typedef struct packed
    {
        logic load_start;
        logic tick;
        logic div_start;
        logic div_sel_y;
        logic load_inc_x;
        logic load_inc_y;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic out_free;
        logic is_start;
        logic step_nz;
        logic div_done;
    } dp_status_t;

endpackage

FILE: rtl/dda_div.sv
// Restoring divider that retires one quotient bit per cycle.
module dda_div
    import dda_pkg::*;
#(
    parameter int NUM_W = COORD_BITS + DEFAULT_FRAC_BITS + 1,
    parameter int DEN_W = COORD_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;

    always_comb
    begin
        rem_sh     = {rem_reg, quo_reg[NUM_W-1]};
        diff       = rem_sh - {1'b0, den_reg};
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done       = busy_reg && (count_reg == '0);
        if (start)
        begin
            quo_next   = dividend;
            rem_next   = '0;
            den_next   = divisor;
            count_next = CW'(NUM_W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                count_next = count_reg - 1'b1;
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = diff[DEN_W-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[DEN_W-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

FILE: rtl/dda_datapath.sv
// Datapath: endpoint setup, position accumulators, increment division and output register.
module dda_datapath
    import dda_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_item_t  cmd,
    input  logic       pix_ready,
    input  ctrl_cmd_t  ctl,
    output dp_status_t st,
    output pix_item_t  pix,
    output logic       pix_valid
);

    // The position carries one integer bit above the screen so that rounding drift past
    // the far edge saturates instead of wrapping into the sign bit.
    localparam int PW    = COORD_BITS + 2 + FRAC_BITS;
    localparam int IW    = FRAC_BITS + 2;
    localparam int NUM_W = COORD_BITS + FRAC_BITS + 1;

    logic signed [PW-1:0]   pos_x_reg, pos_x_next;
    logic signed [PW-1:0]   pos_y_reg, pos_y_next;
    logic signed [IW-1:0]   inc_x_reg, inc_x_next;
    logic signed [IW-1:0]   inc_y_reg, inc_y_next;
    logic [COORD_BITS-1:0]  steps_left_reg, steps_left_next;
    logic                   active_reg, active_next;
    logic [COORD_BITS-1:0]  mag_x_reg, mag_x_next;
    logic [COORD_BITS-1:0]  mag_y_reg, mag_y_next;
    logic                   neg_x_reg, neg_x_next;
    logic                   neg_y_reg, neg_y_next;
    pix_item_t              out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   swap;
    logic [COORD_BITS-1:0]  x1, y1, x2, y2;
    logic signed [COORD_BITS:0] dx, dy, ax_s, ay_s;
    logic [COORD_BITS-1:0]  ax, ay, step;
    logic signed [PW-1:0]   sum_x, sum_y;
    logic [NUM_W-1:0]       div_num;
    logic [NUM_W-1:0]       quotient;
    logic                   div_done;
    logic signed [IW-1:0]   q_pos;
    logic signed [IW-1:0]   inc_new;
    logic                   inc_neg;

    // Floor of a Q position, clamped into the screen on both sides.
    function automatic logic [COORD_BITS-1:0] pixel_of(input logic signed [PW-1:0] p);
        logic [COORD_BITS-1:0] v;
        v = p[PW-1] ? '0 : (p[PW-2] ? '1 : p[PW-3:FRAC_BITS]);
        return v;
    endfunction

    always_comb
    begin
        swap = (cmd.start_x > cmd.end_x) || (cmd.start_y > cmd.end_y);
        x1   = swap ? cmd.end_x   : cmd.start_x;
        y1   = swap ? cmd.end_y   : cmd.start_y;
        x2   = swap ? cmd.start_x : cmd.end_x;
        y2   = swap ? cmd.start_y : cmd.end_y;
        dx   = $signed({1'b0, x2}) - $signed({1'b0, x1});
        dy   = $signed({1'b0, y2}) - $signed({1'b0, y1});
        ax_s = dx[COORD_BITS] ? -dx : dx;
        ay_s = dy[COORD_BITS] ? -dy : dy;
        ax   = ax_s[COORD_BITS-1:0];
        ay   = ay_s[COORD_BITS-1:0];
        step = (ax >= ay) ? ax : ay;
    end

    assign div_num = {1'b0, (ctl.div_sel_y ? mag_y_reg : mag_x_reg), {FRAC_BITS{1'b0}}}
                     + NUM_W'(steps_left_reg >> 1);

    dda_div #(
        .NUM_W (NUM_W),
        .DEN_W (COORD_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (div_num),
        .divisor  (steps_left_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        q_pos   = $signed({1'b0, quotient[FRAC_BITS:0]});
        inc_neg = ctl.load_inc_y ? neg_y_reg : neg_x_reg;
        inc_new = inc_neg ? -q_pos : q_pos;
        sum_x   = pos_x_reg + {{(PW-IW){inc_x_reg[IW-1]}}, inc_x_reg};
        sum_y   = pos_y_reg + {{(PW-IW){inc_y_reg[IW-1]}}, inc_y_reg};
    end

    always_comb
    begin
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        inc_x_next      = inc_x_reg;
        inc_y_next      = inc_y_reg;
        steps_left_next = steps_left_reg;
        active_next     = active_reg;
        mag_x_next      = mag_x_reg;
        mag_y_next      = mag_y_reg;
        neg_x_next      = neg_x_reg;
        neg_y_next      = neg_y_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !pix_ready;

        if (ctl.load_start)
        begin
            pos_x_next      = $signed({2'b00, x1, {FRAC_BITS{1'b0}}});
            pos_y_next      = $signed({2'b00, y1, {FRAC_BITS{1'b0}}});
            inc_x_next      = '0;
            inc_y_next      = '0;
            steps_left_next = step;
            active_next     = (step != '0);
            mag_x_next      = ax;
            mag_y_next      = ay;
            neg_x_next      = dx[COORD_BITS];
            neg_y_next      = dy[COORD_BITS];
            out_next.pixel_x     = x1;
            out_next.pixel_y     = y1;
            out_next.pixel_valid = 1'b1;
            out_next.last        = (step == '0);
            out_valid_next       = 1'b1;
        end
        else if (ctl.tick)
        begin
            out_valid_next = 1'b1;
            if (active_reg)
            begin
                pos_x_next      = sum_x;
                pos_y_next      = sum_y;
                steps_left_next = steps_left_reg - 1'b1;
                active_next     = (steps_left_reg != COORD_BITS'(1));
                out_next.pixel_x     = pixel_of(sum_x);
                out_next.pixel_y     = pixel_of(sum_y);
                out_next.pixel_valid = 1'b1;
                out_next.last        = (steps_left_reg == COORD_BITS'(1));
            end
            else
            begin
                out_next = '0;
            end
        end

        if (ctl.load_inc_x)
        begin
            inc_x_next = inc_new;
        end
        if (ctl.load_inc_y)
        begin
            inc_y_next = inc_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            inc_x_reg      <= '0;
            inc_y_reg      <= '0;
            steps_left_reg <= '0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            inc_x_reg      <= inc_x_next;
            inc_y_reg      <= inc_y_next;
            steps_left_reg <= steps_left_next;
            active_reg     <= active_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_x_reg <= mag_x_next;
        mag_y_reg <= mag_y_next;
        neg_x_reg <= neg_x_next;
        neg_y_reg <= neg_y_next;
        out_reg   <= out_next;
    end

    assign st.out_free = !out_valid_reg || pix_ready;
    assign st.is_start = (cmd.command == CMD_START);
    assign st.step_nz  = (step != '0);
    assign st.div_done = div_done;
    assign pix         = out_reg;
    assign pix_valid   = out_valid_reg;

endmodule

FILE: rtl/dda_ctrl.sv
// Controller state machine: input handshake and sequencing of the two increment divisions.
module dda_ctrl
    import dda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  dp_status_t st,
    output ctrl_cmd_t  ctl
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_ready  = 1'b0;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = st.out_free;
                if (cmd_valid && st.out_free)
                begin
                    if (st.is_start)
                    begin
                        ctl.load_start = 1'b1;
                        if (st.step_nz)
                        begin
                            state_next = ST_START_X;
                        end
                    end
                    else
                    begin
                        ctl.tick = 1'b1;
                    end
                end
            end
            ST_START_X:
            begin
                ctl.div_start = 1'b1;
                state_next    = ST_WAIT_X;
            end
            ST_WAIT_X:
            begin
                if (st.div_done)
                begin
                    ctl.load_inc_x = 1'b1;
                    ctl.div_start  = 1'b1;
                    ctl.div_sel_y  = 1'b1;
                    state_next     = ST_WAIT_Y;
                end
            end
            ST_WAIT_Y:
            begin
                ctl.div_sel_y = 1'b1;
                if (st.div_done)
                begin
                    ctl.load_inc_y = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/dda_line_rasterizer_top.sv
// Top level of the DDA line rasterizer: controller, datapath and checks.
//
// This block draws straight lines one pixel per item. A start item (command 0) loads two
// endpoints, swapping them when the first lies right of or below the second, and
// returns the first pixel right away. It then works out the per-axis increments
// d * 2^FRAC_BITS / step, rounded to nearest, on one shared restoring divider that
// retires one quotient bit per cycle; the x and y divisions run back to back, and after
// a start item cmd_ready stays low until both have finished. A start with equal
// endpoints returns a single pixel with last set and does not stall. Each tick item
// (command 1) adds the increments to the fixed-point position and returns the floor of
// the position as one item per cycle while the receiver keeps taking results, with last
// raised on the final pixel of the line; a tick with no line active returns an item with
// every field zero. A new start abandons any line in progress. Results sit in an output
// register, so an item is accepted in the same cycle that the previous result is taken.
module dda_line_rasterizer_top
    import dda_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_item_t cmd,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    output pix_item_t pix,
    output logic      pix_valid,
    input  logic      pix_ready
);

    ctrl_cmd_t  ctl;
    dp_status_t st;

    // The controller owns the input handshake and the division sequence.
    dda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .st        (st),
        .ctl       (ctl)
    );

    // The datapath holds the line state, the divider and the result register.
    dda_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .pix_ready (pix_ready),
        .ctl       (ctl),
        .st        (st),
        .pix       (pix),
        .pix_valid (pix_valid)
    );

    // Every accepted item leaves a result in the output register on the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> pix_valid)
        else $error("accepted item produced no result");

    // A start with distinct endpoints must stall the input while the divider runs.
    a_start_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && st.is_start && st.step_nz |=> !cmd_ready)
        else $error("input accepted during increment division");

    // The divider only finishes while the input is held off.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        st.div_done |-> !cmd_ready)
        else $error("divider finished while controller was idle");

    // Increments load only when the divider reports a finished quotient.
    a_inc_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load_inc_x || ctl.load_inc_y) |-> st.div_done)
        else $error("increment loaded without a finished division");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the DDA line rasterizer: directed table, random lines, pixel checks.
module testbench;
    import dda_pkg::*;

    // Width of the fixed-point position and the run limits. The block stalls its input after
    // a start while it divides, so the drain wait and the watchdog are sized well beyond that.
    localparam int FRAC_BITS    = DEFAULT_FRAC_BITS;
    localparam int POS_W        = COORD_BITS + 1 + FRAC_BITS;
    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASE_ITEMS  = 100;
    localparam int NUM_PHASES   = 5;

    logic      clk;
    logic      rst_n;
    cmd_item_t cmd;
    logic      cmd_valid;
    logic      cmd_ready;
    pix_item_t pix;
    logic      pix_valid;
    logic      pix_ready;

    dda_line_rasterizer_top #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .pix       (pix),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready)
    );

    // One row of the directed table. When typed is set, want holds the pixel that can be
    // read straight off the endpoints; otherwise the predictor supplies the expected pixel.
    typedef struct {
        cmd_item_t item;
        bit        typed;
        pix_item_t want;
    } stim_row_t;

    stim_row_t directed_rows[$];
    pix_item_t pixels_due[$];

    // Predictor state: the current line position and per-tick increments in signed fixed
    // point, how many ticks remain, and whether a line is still being drawn.
    logic signed [POS_W-1:0] cur_x;
    logic signed [POS_W-1:0] cur_y;
    logic signed [POS_W-1:0] step_x;
    logic signed [POS_W-1:0] step_y;
    logic [COORD_BITS:0]     ticks_to_go;
    bit                      line_live;

    // Idle mix of the current phase, the hold-off request to the receiver, and the tallies.
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_go;
    int quiet_cycles;
    int n_errors;
    int items_sent;
    int n_starts;
    int n_ticks;
    int n_pixels;
    int n_line_ends;
    int n_blank;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Floor of a fixed-point position, clamped into the screen. Rounding of the increments
    // can pull a position a fraction below zero, which still lands on pixel 0.
    function automatic logic [COORD_BITS-1:0] floor_pixel(input logic signed [POS_W-1:0] p);
        logic signed [POS_W-1:0] whole;
        whole = p >>> FRAC_BITS;
        if (p < 0)
            return '0;
        if (whole > COORD_MAX)
            return COORD_BITS'(COORD_MAX);
        return whole[COORD_BITS-1:0];
    endfunction

    // Per-tick increment d / len in fixed point, rounded to nearest with ties away from zero.
    function automatic logic signed [POS_W-1:0] round_inc(input int d, input int len);
        longint mag;
        longint q;
        mag = (d < 0) ? -d : d;
        q   = ((mag << FRAC_BITS) + len / 2) / len;
        return POS_W'((d < 0) ? -q : q);
    endfunction

    // Advances the predictor by one accepted item and returns the pixel it must produce.
    function automatic pix_item_t predict_pixel(input cmd_item_t c);
        pix_item_t res;
        int        x1;
        int        y1;
        int        x2;
        int        y2;
        int        swap;
        int        dx;
        int        dy;
        int        len;
        res = '0;
        if (c.command == CMD_START)
        begin
            x1 = c.start_x;
            y1 = c.start_y;
            x2 = c.end_x;
            y2 = c.end_y;
            // The line is always drawn from the endpoint that is not right of or below the
            // other one on both axes, so a mixed slope starts from the swapped pair.
            if (x1 > x2 || y1 > y2)
            begin
                swap = x1; x1 = x2; x2 = swap;
                swap = y1; y1 = y2; y2 = swap;
            end
            dx  = x2 - x1;
            dy  = y2 - y1;
            len = (dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                              : (dy < 0 ? -dy : dy);
            cur_x = POS_W'(longint'(x1) << FRAC_BITS);
            cur_y = POS_W'(longint'(y1) << FRAC_BITS);
            if (len == 0)
            begin
                step_x      = '0;
                step_y      = '0;
                ticks_to_go = '0;
                line_live   = 1'b0;
            end
            else
            begin
                step_x      = round_inc(dx, len);
                step_y      = round_inc(dy, len);
                ticks_to_go = (COORD_BITS + 1)'(len);
                line_live   = 1'b1;
            end
            res.pixel_x     = floor_pixel(cur_x);
            res.pixel_y     = floor_pixel(cur_y);
            res.pixel_valid = 1'b1;
            res.last        = (len == 0);
        end
        else if (line_live)
        begin
            cur_x           = cur_x + step_x;
            cur_y           = cur_y + step_y;
            ticks_to_go     = ticks_to_go - 1'b1;
            res.pixel_x     = floor_pixel(cur_x);
            res.pixel_y     = floor_pixel(cur_y);
            res.pixel_valid = 1'b1;
            res.last        = (ticks_to_go == 0);
            if (ticks_to_go == 0)
                line_live = 1'b0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offers one item, idling first as the phase asks, and records the expected pixel on the
    // edge where the block takes it. Valid is left high; the next call or a drain lowers it.
    task automatic send_item(input cmd_item_t c, input bit typed, input pix_item_t want);
        pix_item_t guess;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        guess = predict_pixel(c);
        pixels_due.push_back(typed ? want : guess);
        items_sent++;
        if (c.command == CMD_START)
            n_starts++;
        else
            n_ticks++;
    endtask

    // Stops offering items and waits until every expected pixel has been taken.
    task automatic drain_pixels();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pixels_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input command_t op, input int x1, y1, x2, y2,
                           input bit typed = 1'b0, input int px = 0, py = 0,
                           input bit pv = 1'b0, pl = 1'b0);
        stim_row_t r;
        r.item.command        = op;
        r.item.start_x        = COORD_BITS'(x1);
        r.item.start_y        = COORD_BITS'(y1);
        r.item.end_x          = COORD_BITS'(x2);
        r.item.end_y          = COORD_BITS'(y2);
        r.typed               = typed;
        r.want.pixel_x        = COORD_BITS'(px);
        r.want.pixel_y        = COORD_BITS'(py);
        r.want.pixel_valid    = pv;
        r.want.last           = pl;
        directed_rows.push_back(r);
    endtask

    // Coordinates lean toward the screen edges so that clamping near 0 and the top is hit.
    function automatic int rand_coord();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return 0;
        if (pick == 1)
            return COORD_MAX;
        return $urandom_range(COORD_MAX);
    endfunction

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    // A tick carries junk in its endpoint fields; the block must ignore them.
    function automatic cmd_item_t make_tick();
        cmd_item_t c;
        c.command = CMD_TICK;
        c.start_x = COORD_BITS'($urandom);
        c.start_y = COORD_BITS'($urandom);
        c.end_x   = COORD_BITS'($urandom);
        c.end_y   = COORD_BITS'($urandom);
        return c;
    endfunction

    function automatic cmd_item_t make_start(input int x1, y1, x2, y2);
        cmd_item_t c;
        c.command = CMD_START;
        c.start_x = COORD_BITS'(x1);
        c.start_y = COORD_BITS'(y1);
        c.end_x   = COORD_BITS'(x2);
        c.end_y   = COORD_BITS'(y2);
        return c;
    endfunction

    // One random burst. Most bursts draw a short line to its end and a few ticks past it;
    // the rest are single points, long lines that get abandoned, lines cut short, and noise.
    task automatic random_burst();
        cmd_item_t c;
        int        kind;
        int        x1;
        int        y1;
        int        x2;
        int        y2;
        int        len;
        int        n;
        kind = $urandom_range(99);
        if (kind < 12)
        begin
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                c         = make_tick();
                c.command = command_t'($urandom_range(1));
                send_item(c, 1'b0, '0);
            end
            return;
        end
        x1 = rand_coord();
        y1 = rand_coord();
        if (kind < 27)
        begin
            x2 = x1;
            y2 = y1;
        end
        else if (kind < 42)
        begin
            x2 = rand_coord();
            y2 = rand_coord();
        end
        else
        begin
            x2 = clamp_coord(x1 + int'($urandom_range(24)) - 12);
            y2 = clamp_coord(y1 + int'($urandom_range(24)) - 12);
        end
        send_item(make_start(x1, y1, x2, y2), 1'b0, '0);
        len = (x2 > x1 ? x2 - x1 : x1 - x2);
        if ((y2 > y1 ? y2 - y1 : y1 - y2) > len)
            len = (y2 > y1 ? y2 - y1 : y1 - y2);
        if (kind >= 27 && kind < 42 && len > 30)
            n = $urandom_range(0, 30);
        else if ($urandom_range(99) < 15)
            n = $urandom_range(0, len);
        else
            n = len + $urandom_range(0, 2);
        repeat (n)
            send_item(make_tick(), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // Ready follows the stall mix of the phase. On request it holds off for a long stretch,
    // counted here, so that the output register fills and the block stops taking ticks.
    initial
    begin
        pix_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                hold_go = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    pix_ready <= 1'b0;
                    @(posedge clk);
                end
            end
            pix_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input pix_item_t got,
                                   input pix_item_t want);
        n_errors++;
        $display("ERROR %s: got x=%0d y=%0d valid=%0b last=%0b, want x=%0d y=%0d %s",
                 what, got.pixel_x, got.pixel_y, got.pixel_valid, got.last,
                 want.pixel_x, want.pixel_y,
                 $sformatf("valid=%0b last=%0b", want.pixel_valid, want.last));
    endtask

    // Every taken pixel is checked against the oldest expectation, one field at a time.
    always @(posedge clk)
    begin
        pix_item_t want;
        if (rst_n && pix_valid && pix_ready)
        begin
            if (pixels_due.size() == 0)
            begin
                report_mismatch("pixel with nothing expected", pix, '0);
            end
            else
            begin
                want = pixels_due.pop_front();
                if (pix.pixel_x !== want.pixel_x || pix.pixel_y !== want.pixel_y ||
                    pix.pixel_valid !== want.pixel_valid || pix.last !== want.last)
                    report_mismatch("pixel differs", pix, want);
                if (pix.pixel_valid === 1'b1)
                    n_pixels++;
                else
                    n_blank++;
                if (pix.last === 1'b1)
                    n_line_ends++;
            end
        end
    end

    // Watchdog: a long run of cycles in which neither side moves an item means the block hung.
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (pix_valid && pix_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog: no item moved for %0d cycles.", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        int send_mix [NUM_PHASES];
        int recv_mix [NUM_PHASES];
        int goal;

        // Phases: no idling, sender mostly idle, receiver mostly stalled, both somewhat
        // busy, then no idling again with the long receiver hold-off at its start.
        send_mix = '{0, 83, 0, 30, 0};
        recv_mix = '{0, 0, 83, 30, 0};

        cmd            = '0;
        cmd_valid      = 1'b0;
        rst_n          = 1'b0;
        hold_go        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        line_live      = 1'b0;
        cur_x          = '0;
        cur_y          = '0;
        step_x         = '0;
        step_y         = '0;
        ticks_to_go    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Typed rows are first pixels of a start, single-point lines and
        // ticks with no line active; the rest are left to the predictor.
        add_row(CMD_TICK,  0, 0, 0, 0, 1'b1, 0, 0, 1'b0, 1'b0);          // tick right after reset
        add_row(CMD_START, 5, 5, 5, 5, 1'b1, 5, 5, 1'b1, 1'b1);          // equal endpoints
        add_row(CMD_TICK,  0, 0, 0, 0, 1'b1, 0, 0, 1'b0, 1'b0);
        add_row(CMD_START, 0, 0, 1023, 1023, 1'b1, 0, 0, 1'b1, 1'b0);    // full diagonal
        add_row(CMD_TICK,  0, 0, 0, 0);
        add_row(CMD_TICK,  1023, 1023, 1023, 1023);
        add_row(CMD_TICK,  0, 0, 0, 0);
        add_row(CMD_START, 1023, 1023, 0, 0, 1'b1, 0, 0, 1'b1, 1'b0);    // swapped, abandons
        add_row(CMD_TICK,  0, 0, 0, 0);
        add_row(CMD_START, 1023, 0, 0, 1023, 1'b1, 0, 1023, 1'b1, 1'b0); // falling y
        add_row(CMD_TICK,  0, 0, 0, 0);
        add_row(CMD_TICK,  0, 0, 0, 0);
        add_row(CMD_START, 0, 1023, 1023, 0, 1'b1, 1023, 0, 1'b1, 1'b0); // falling x
        add_row(CMD_TICK,  0, 0, 0, 0);
        add_row(CMD_START, 3, 7, 4, 7, 1'b1, 3, 7, 1'b1, 1'b0);          // one-step line
        add_row(CMD_TICK,  0, 0, 0, 0);
        add_row(CMD_TICK,  0, 0, 0, 0, 1'b1, 0, 0, 1'b0, 1'b0);          // after the end
        add_row(CMD_START, 1023, 1023, 1023, 1023, 1'b1, 1023, 1023, 1'b1, 1'b1);
        add_row(CMD_START, 0, 0, 1023, 1, 1'b1, 0, 0, 1'b1, 1'b0);       // shallow, abandoned
        add_row(CMD_START, 10, 20, 13, 25, 1'b1, 10, 20, 1'b1, 1'b0);
        repeat (5)
            add_row(CMD_TICK, 0, 0, 0, 0);
        add_row(CMD_TICK,  0, 0, 0, 0, 1'b1, 0, 0, 1'b0, 1'b0);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        drain_pixels();

        // Random part, phase by phase. Before each new phase the sender pauses until every
        // expected pixel has arrived.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            send_idle_pct  = send_mix[ph];
            recv_stall_pct = recv_mix[ph];
            goal           = items_sent + PHASE_ITEMS;
            if (ph == NUM_PHASES - 1)
            begin
                // Long line, then a receiver hold-off while the ticks keep coming.
                send_item(make_start(0, 0, 900, 300), 1'b0, '0);
                hold_go = 1'b1;
                repeat (40)
                    send_item(make_tick(), 1'b0, '0);
            end
            while (items_sent < goal)
                random_burst();
            drain_pixels();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d items (%0d starts, %0d ticks) giving %0d pixels, %0d line ends",
                 items_sent, n_starts, n_ticks, n_pixels, n_line_ends);
        $display("and %0d blank results, under four idle mixes and a %0d-cycle receiver hold-off.",
                 n_blank, HOLD_CYCLES);
        if (n_errors == 0 && pixels_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
rtl/dda_pkg.sv
rtl/dda_div.sv
rtl/dda_datapath.sv
rtl/dda_ctrl.sv
rtl/dda_line_rasterizer_top.sv
verif/testbench.sv
